>>> design/lzd_pkg.sv
// shared types and constants for the lz77 stream decompressor
// used by lzd_ctrl, lzd_dp and lz77_stream_decompressor_top
package lzd_pkg;

    localparam logic [7:0] TAG_VALUE = 8'h10;
    localparam logic [4:0] MIN_MATCH = 5'd3;

    typedef enum logic [2:0] {
        STAT_DATA    = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_BAD_TAG = 3'd2,
        STAT_TOO_FAR = 3'd3,
        STAT_SHORT   = 3'd4
    } stat_t;

    // controller to datapath
    typedef struct packed {
        logic  clr;
        logic  hdr_load;
        logic  flag_load;
        logic  mh_load;
        logic  match_start;
        logic  copy_rd;
        logic  push;
        logic  src_hist;
        logic  adv;
        logic  out_load;
        logic  out_last;
        stat_t out_status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic tag_ok;
        logic hdr_done;
        logic size_zero;
        logic flag_bit;
        logic bit_last;
        logic lit_short;
        logic done_next;
        logic too_far;
        logic copy_short;
        logic count_last;
        logic last_hold;
    } status_t;

endpackage

>>> design/lz77_stream_decompressor_top.sv
// top level of the lz77 (type 0x10) stream decompressor
// depends on lzd_pkg, lzd_ctrl and lzd_dp
//
// Header, flag and literal bytes are taken one per cycle while the output register has
// room. Each byte of a back-reference is copied by a registered read of the history
// memory, then the write and the output transfer, which waits for room in the output
// register; no input is taken until the copy is done. Error and empty-stream results
// carry tlast; data already sent before an error is to be dropped. The history needs
// no clearing pass after reset.
module lz77_stream_decompressor_top #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic [2:0] m_tuser    // [2:0] out_status
);
    import lzd_pkg::*;

    cmd_t    cmd;
    status_t status;
    stat_t   m_status;

    lzd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lzd_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_byte   (m_tdata),
        .m_last   (m_tlast),
        .m_status (m_status)
    );

    assign m_tuser = m_status;

    // a result is never loaded over one still waiting
    a_load_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

    // no input is taken while a back-reference is being copied
    a_copy_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.copy_rd |-> !s_tready)
        else $error("input taken during copy");

    // every history write produces a data result
    a_push_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (cmd.out_load && cmd.out_status == STAT_DATA))
        else $error("history write without output byte");

    // non-data results always close the stream
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_DATA) |-> m_tlast)
        else $error("status result without tlast");

endmodule

>>> design/lzd_ctrl.sv
// control state machine of the lz77 stream decompressor
// depends on lzd_pkg for the command and status structs
module lzd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    input  lzd_pkg::status_t status,
    output lzd_pkg::cmd_t    cmd
);
    import lzd_pkg::*;

    typedef enum logic [7:0] {
        S_TAG   = 8'b0000_0001,
        S_SIZE  = 8'b0000_0010,
        S_FLAG  = 8'b0000_0100,
        S_ITEM  = 8'b0000_1000,
        S_MLO   = 8'b0001_0000,
        S_DRAIN = 8'b0010_0000,
        S_CRD   = 8'b0100_0000,
        S_CWR   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;
    logic   do_fail;
    stat_t  fail_code;
    logic   do_adv;
    logic   adv_last;

    assign s_tready = (state_reg != S_CRD) && (state_reg != S_CWR) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_status = STAT_DATA;
        do_fail    = 1'b0;
        fail_code  = STAT_SHORT;
        do_adv     = 1'b0;
        adv_last   = s_tlast;
        unique case (state_reg)
            S_TAG: begin
                if (accept) begin
                    if (!status.tag_ok) begin
                        do_fail   = 1'b1;
                        fail_code = STAT_BAD_TAG;
                    end else if (s_tlast) begin
                        do_fail = 1'b1;
                    end else begin
                        state_next = S_SIZE;
                    end
                end
            end
            S_SIZE: begin
                if (accept) begin
                    cmd.hdr_load = 1'b1;
                    if (!status.hdr_done) begin
                        do_fail = s_tlast;
                    end else if (status.size_zero) begin
                        do_fail   = 1'b1;
                        fail_code = STAT_EMPTY;
                    end else if (s_tlast) begin
                        do_fail = 1'b1;
                    end else begin
                        state_next = S_FLAG;
                    end
                end
            end
            S_FLAG: begin
                if (accept) begin
                    if (s_tlast) begin
                        do_fail = 1'b1;
                    end else begin
                        cmd.flag_load = 1'b1;
                        state_next    = S_ITEM;
                    end
                end
            end
            S_ITEM: begin
                if (accept) begin
                    if (!status.flag_bit) begin
                        if (s_tlast && status.lit_short) begin
                            do_fail = 1'b1;
                        end else begin
                            cmd.push     = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.out_last = status.done_next;
                            do_adv       = 1'b1;
                        end
                    end else if (s_tlast) begin
                        do_fail = 1'b1;
                    end else begin
                        cmd.mh_load = 1'b1;
                        state_next  = S_MLO;
                    end
                end
            end
            S_MLO: begin
                if (accept) begin
                    if (status.too_far) begin
                        do_fail   = 1'b1;
                        fail_code = STAT_TOO_FAR;
                    end else if (s_tlast && status.copy_short) begin
                        do_fail = 1'b1;
                    end else begin
                        cmd.match_start = 1'b1;
                        state_next      = S_CRD;
                    end
                end
            end
            S_DRAIN: begin
                if (accept && s_tlast) begin
                    cmd.clr    = 1'b1;
                    state_next = S_TAG;
                end
            end
            S_CRD: begin
                cmd.copy_rd = 1'b1;
                state_next  = S_CWR;
            end
            S_CWR: begin
                if (status.out_free) begin
                    cmd.push     = 1'b1;
                    cmd.src_hist = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_last = status.done_next;
                    adv_last     = status.last_hold;
                    if (status.count_last) begin
                        do_adv = 1'b1;
                    end else begin
                        state_next = S_CRD;
                    end
                end
            end
            default: begin
                cmd.clr    = 1'b1;
                state_next = S_TAG;
            end
        endcase

        if (do_fail) begin
            cmd.out_load   = 1'b1;
            cmd.out_last   = 1'b1;
            cmd.out_status = fail_code;
            cmd.clr        = s_tlast;
            state_next     = s_tlast ? S_TAG : S_DRAIN;
        end

        if (do_adv) begin
            cmd.adv = 1'b1;
            if (status.done_next) begin
                cmd.clr    = adv_last;
                state_next = adv_last ? S_TAG : S_DRAIN;
            end else if (status.bit_last) begin
                state_next = S_FLAG;
            end else begin
                state_next = S_ITEM;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_TAG;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/lzd_dp.sv
// datapath of the lz77 stream decompressor: header and flag registers,
// history memory, copy counters and output register; depends on lzd_pkg
module lzd_dp #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  lzd_pkg::cmd_t    cmd,
    output lzd_pkg::status_t status,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [7:0]       m_byte,
    output logic             m_last,
    output lzd_pkg::stat_t   m_status
);
    import lzd_pkg::*;

    localparam int PW = $clog2(HISTORY_DEPTH);
    localparam logic [PW:0]   DEPTH_W = (PW + 1)'(HISTORY_DEPTH);
    localparam logic [PW-1:0] PTR_MAX = PW'(HISTORY_DEPTH - 1);

    logic [1:0]    hdr_idx_reg;
    logic [23:0]   target_reg;
    logic [23:0]   target_next;
    logic [23:0]   prod_reg;
    logic [7:0]    flag_reg;
    logic [3:0]    bit_reg;
    logic [7:0]    mh_reg;
    logic [PW-1:0] hp_reg;
    logic [12:0]   dist_reg;
    logic [4:0]    count_reg;
    logic          last_hold_reg;
    logic [7:0]    rd_data_reg;
    logic [7:0]    hist_mem [HISTORY_DEPTH];

    logic          m_valid_reg;
    logic [7:0]    m_byte_reg;
    logic          m_last_reg;
    stat_t         m_status_reg;

    logic [12:0]   dist_in;
    logic [4:0]    match_len;
    logic [23:0]   remaining;
    logic [4:0]    count_in;
    logic [PW:0]   dist_w;
    logic [PW:0]   rd_diff;
    logic [PW-1:0] rd_addr;
    logic [7:0]    wdata;
    logic [7:0]    out_byte;

    always_comb begin
        target_next = target_reg;
        case (hdr_idx_reg)
            2'd0:    target_next[7:0]   = in_byte;
            2'd1:    target_next[15:8]  = in_byte;
            2'd2:    target_next[23:16] = in_byte;
            default: target_next = target_reg;
        endcase
    end

    assign dist_in    = {1'b0, mh_reg[3:0], in_byte} + 13'd1;
    assign match_len  = {1'b0, mh_reg[7:4]} + MIN_MATCH;
    assign remaining  = target_reg - prod_reg;
    assign count_in   = status.copy_short ? match_len : remaining[4:0];

    assign dist_w  = (PW + 1)'(dist_reg);
    assign rd_diff = ({1'b0, hp_reg} >= dist_w) ? ({1'b0, hp_reg} - dist_w)
                                                : ({1'b0, hp_reg} + DEPTH_W - dist_w);
    assign rd_addr = rd_diff[PW-1:0];

    assign wdata    = cmd.src_hist ? rd_data_reg : in_byte;
    assign out_byte = (cmd.out_status == STAT_DATA) ? wdata : 8'h00;

    always_comb begin
        status.out_free   = !m_valid_reg || m_tready;
        status.tag_ok     = (in_byte == TAG_VALUE);
        status.hdr_done   = (hdr_idx_reg == 2'd2);
        status.size_zero  = (target_next == 24'd0);
        status.flag_bit   = flag_reg[3'd7 - bit_reg[2:0]];
        status.bit_last   = (bit_reg == 4'd7);
        status.lit_short  = (({1'b0, prod_reg} + 25'd1) < {1'b0, target_reg});
        status.done_next  = ((prod_reg + 24'd1) == target_reg);
        status.too_far    = ({11'd0, dist_in} > prod_reg);
        status.copy_short = ({19'd0, match_len} < remaining);
        status.count_last = (count_reg == 5'd1);
        status.last_hold  = last_hold_reg;
    end

    // history memory
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            hist_mem[hp_reg] <= wdata;
        end
        if (cmd.copy_rd) begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    // match operands
    always_ff @(posedge aclk) begin
        if (cmd.match_start) begin
            dist_reg      <= dist_in;
            last_hold_reg <= in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.match_start) begin
            count_reg <= count_in;
        end else if (cmd.push && cmd.src_hist) begin
            count_reg <= count_reg - 5'd1;
        end
    end

    // stream state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr) begin
            hdr_idx_reg <= '0;
            target_reg  <= '0;
            prod_reg    <= '0;
            flag_reg    <= '0;
            bit_reg     <= '0;
            mh_reg      <= '0;
            hp_reg      <= '0;
        end else begin
            if (cmd.hdr_load) begin
                target_reg  <= target_next;
                hdr_idx_reg <= status.hdr_done ? 2'd0 : hdr_idx_reg + 2'd1;
            end
            if (cmd.flag_load) begin
                flag_reg <= in_byte;
                bit_reg  <= '0;
            end else if (cmd.adv) begin
                bit_reg <= bit_reg + 4'd1;
            end
            if (cmd.mh_load) begin
                mh_reg <= in_byte;
            end
            if (cmd.push) begin
                prod_reg <= prod_reg + 24'd1;
                hp_reg   <= (hp_reg == PTR_MAX) ? '0 : hp_reg + PW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_byte_reg   <= out_byte;
            m_last_reg   <= cmd.out_last;
            m_status_reg <= cmd.out_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_byte   = m_byte_reg;
    assign m_last   = m_last_reg;
    assign m_status = m_status_reg;

endmodule

>>> bench/lz77_stream_decompressor_top_tb.sv
`timescale 1ns / 1ps
// self-checking bench for lz77_stream_decompressor_top: random lz10 streams with a
// bit-accurate decoder model in the bench; depends on lzd_pkg and the design files

module lz77_stream_decompressor_top_tb;

    import lzd_pkg::*;

    localparam int WINDOW      = 4096;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum logic [2:0] {
        DEC_TAG,
        DEC_HDR,
        DEC_FLAG,
        DEC_ITEM,
        DEC_MATCH_LO,
        DEC_DRAIN
    } dec_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        stat_t      status;
    } out_item_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;
    logic [2:0] m_tuser;            // [2:0] out_status

    in_item_t  pending_in[$];
    out_item_t expected_out[$];

    int unsigned items_queued    = 0;
    int unsigned fail_count      = 0;
    int unsigned cycle_count     = 0;
    int          send_gap        = 0;
    int          stall_left      = 0;
    bit          hold_request    = 1'b0;
    bit          sender_steady   = 1'b0;
    bit          receiver_steady = 1'b0;

    // decoder model state
    dec_phase_t  dec_phase;
    int unsigned hdr_idx;
    int unsigned size_goal;
    int unsigned made;
    logic [7:0]  flags;
    int unsigned bit_idx;
    logic [7:0]  match_hi;
    logic [7:0]  window [0:WINDOW-1];
    logic [11:0] wr_ptr;

    lz77_stream_decompressor_top #(
        .HISTORY_DEPTH(WINDOW)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void restart_stream();
        dec_phase = DEC_TAG;
        hdr_idx   = 0;
        size_goal = 0;
        made      = 0;
        flags     = 8'h00;
        bit_idx   = 0;
        match_hi  = 8'h00;
        wr_ptr    = 12'd0;
    endfunction

    function automatic void expect_result(logic [7:0] data, logic last, stat_t status);
        out_item_t r;
        r.data   = data;
        r.last   = last;
        r.status = status;
        expected_out.push_back(r);
    endfunction

    function automatic void end_stream(logic lst);
        if (lst) begin
            restart_stream();
        end else begin
            dec_phase = DEC_DRAIN;
        end
    endfunction

    function automatic void stream_error(stat_t status, logic lst);
        expect_result(8'h00, 1'b1, status);
        end_stream(lst);
    endfunction

    function automatic void store_byte(logic [7:0] v);
        window[wr_ptr] = v;
        wr_ptr = wr_ptr + 12'd1;
        made = (made + 1) & 32'h00FF_FFFF;
    endfunction

    function automatic void next_element(logic lst);
        bit_idx++;
        if (made == size_goal) begin
            end_stream(lst);
        end else if (bit_idx >= 8) begin
            dec_phase = DEC_FLAG;
        end else begin
            dec_phase = DEC_ITEM;
        end
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic lst);
        int unsigned len;
        int unsigned distance;
        int unsigned remaining;
        int unsigned count;
        int unsigned k;
        logic [11:0] rd_idx;
        logic [7:0]  v;
        case (dec_phase)
            DEC_TAG: begin
                if (b != TAG_VALUE) begin
                    stream_error(STAT_BAD_TAG, lst);
                end else if (lst) begin
                    stream_error(STAT_SHORT, lst);
                end else begin
                    dec_phase = DEC_HDR;
                    hdr_idx   = 0;
                    size_goal = 0;
                end
            end
            DEC_HDR: begin
                size_goal = size_goal | ({24'd0, b} << (8 * hdr_idx));
                hdr_idx++;
                if (hdr_idx < 3) begin
                    if (lst) stream_error(STAT_SHORT, lst);
                end else begin
                    hdr_idx = 0;
                    if (size_goal == 0) begin
                        stream_error(STAT_EMPTY, lst);
                    end else if (lst) begin
                        stream_error(STAT_SHORT, lst);
                    end else begin
                        dec_phase = DEC_FLAG;
                    end
                end
            end
            DEC_FLAG: begin
                if (lst) begin
                    stream_error(STAT_SHORT, lst);
                end else begin
                    flags     = b;
                    bit_idx   = 0;
                    dec_phase = DEC_ITEM;
                end
            end
            DEC_ITEM: begin
                if (!flags[3'(7 - bit_idx)]) begin
                    if (lst && made + 1 < size_goal) begin
                        stream_error(STAT_SHORT, lst);
                    end else begin
                        store_byte(b);
                        expect_result(b, made == size_goal, STAT_DATA);
                        next_element(lst);
                    end
                end else if (lst) begin
                    stream_error(STAT_SHORT, lst);
                end else begin
                    match_hi  = b;
                    dec_phase = DEC_MATCH_LO;
                end
            end
            DEC_MATCH_LO: begin
                len      = match_hi[7:4] + 3;
                distance = {20'd0, match_hi[3:0], b} + 1;
                if (distance > made) begin
                    stream_error(STAT_TOO_FAR, lst);
                end else begin
                    remaining = size_goal - made;
                    count = (len < remaining) ? len : remaining;
                    if (lst && count < remaining) begin
                        stream_error(STAT_SHORT, lst);
                    end else begin
                        for (k = 0; k < count; k++) begin
                            rd_idx = wr_ptr - distance[11:0];
                            v = window[rd_idx];
                            store_byte(v);
                            expect_result(v, made == size_goal, STAT_DATA);
                        end
                        next_element(lst);
                    end
                end
            end
            DEC_DRAIN: begin
                if (lst) restart_stream();
            end
            default: begin
                restart_stream();
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // input side: one transfer per handshake, gaps drawn after each item unless the sender is steady
    always @(posedge aclk) begin
        in_item_t next_in;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_in.size() > 0) begin
                    next_in = pending_in.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_in.data;
                    s_tlast  <= next_in.last;
                    send_gap = sender_steady ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!receiver_steady && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_out.size() == 0) begin
                $error("unexpected transfer: out_byte %02h out_last %0b out_status %0d",
                       m_tdata, m_tlast, m_tuser);
                fail_count++;
            end else begin
                want = expected_out.pop_front();
                if (m_tdata !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("out_last: expected %0b, got %0b", want.last, m_tlast);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("out_status: expected %0d, got %0d", want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void add_item(logic [7:0] data, logic last, bit counted);
        in_item_t it;
        it.data = data;
        it.last = last;
        pending_in.push_back(it);
        if (counted) items_queued++;
    endfunction

    // builds one stream; may cut it short or aim a back-reference too far
    task automatic queue_stream(input int unsigned size, input bit allow_far,
                                input bit truncate);
        logic [7:0]  gen_bytes[$];
        logic [7:0]  flag;
        int unsigned made_gen;
        int unsigned len;
        int unsigned distance;
        int unsigned flag_pos;
        int unsigned n;
        int unsigned k;
        int unsigned trail;
        gen_bytes.push_back(TAG_VALUE);
        gen_bytes.push_back(size[7:0]);
        gen_bytes.push_back(size[15:8]);
        gen_bytes.push_back(size[23:16]);
        made_gen = 0;
        while (made_gen < size) begin
            flag_pos = gen_bytes.size();
            flag = 8'($urandom_range(0, 255));
            gen_bytes.push_back(8'h00);
            for (k = 0; k < 8 && made_gen < size; k++) begin
                if (made_gen > 0 && $urandom_range(0, 2) == 0) begin
                    len      = $urandom_range(3, 18);
                    distance = $urandom_range(1, (made_gen > WINDOW) ? WINDOW : made_gen);
                    if (allow_far && $urandom_range(0, 5) == 0) begin
                        distance = made_gen + $urandom_range(1, 16);
                        if (distance > WINDOW) distance = WINDOW;
                    end
                    flag[3'(7 - k)] = 1'b1;
                    gen_bytes.push_back({len[3:0] - 4'd3,
                                         distance[11:8] - {3'd0, distance[7:0] == 0}});
                    gen_bytes.push_back(distance[7:0] - 8'd1);
                    made_gen += len;
                end else begin
                    flag[3'(7 - k)] = 1'b0;
                    gen_bytes.push_back(8'($urandom_range(0, 255)));
                    made_gen++;
                end
            end
            gen_bytes[flag_pos] = flag;
        end
        n = gen_bytes.size();
        if (truncate) n = $urandom_range(1, n - 1);
        trail = (truncate || $urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
        for (k = 0; k < n; k++) add_item(gen_bytes[k], trail == 0 && k == n - 1, 1'b1);
        for (k = 1; k <= trail; k++) add_item(8'($urandom_range(0, 255)), k == trail, 1'b0);
    endtask

    task automatic queue_noise();
        int unsigned n;
        int unsigned k;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) add_item(8'($urandom_range(0, 255)), k == n - 1, 1'b1);
    endtask

    task automatic run_random(input int unsigned budget);
        int unsigned goal;
        int unsigned r;
        int unsigned size;
        goal = items_queued + budget;
        while (items_queued < goal) begin
            r = $urandom_range(0, 99);
            if (r < 70) size = $urandom_range(1, 24);
            else if (r < 96) size = $urandom_range(25, 120);
            else size = $urandom_range(200, 600);
            r = $urandom_range(0, 99);
            if (r < 75) queue_stream(size, 1'b0, 1'b0);
            else if (r < 85) queue_stream(size, 1'b0, 1'b1);
            else if (r < 93) queue_stream(size, 1'b1, 1'b0);
            else queue_noise();
        end
    endtask

    // checked between edges so that the driver's updates have settled
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_in.size() != 0 || s_tvalid || expected_out.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        restart_stream();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // bad tag that also ends the input
        add_item(8'hEF, 1'b1, 1'b1);
        // input ends on the tag
        add_item(TAG_VALUE, 1'b1, 1'b1);
        // zero size
        add_item(TAG_VALUE, 1'b0, 1'b1); add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h00, 1'b0, 1'b1);     add_item(8'h00, 1'b1, 1'b1);
        // literal then a longest match cut off at the size
        add_item(TAG_VALUE, 1'b0, 1'b1); add_item(8'h05, 1'b0, 1'b1);
        add_item(8'h00, 1'b0, 1'b1);     add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h40, 1'b0, 1'b1);     add_item(8'hA5, 1'b0, 1'b1);
        add_item(8'hF0, 1'b0, 1'b1);     add_item(8'h00, 1'b1, 1'b1);
        // farthest distance after one byte, then a trailing byte
        add_item(TAG_VALUE, 1'b0, 1'b1); add_item(8'h03, 1'b0, 1'b1);
        add_item(8'h00, 1'b0, 1'b1);     add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h40, 1'b0, 1'b1);     add_item(8'h5A, 1'b0, 1'b1);
        add_item(8'h0F, 1'b0, 1'b1);     add_item(8'hFF, 1'b0, 1'b1);
        add_item(8'h33, 1'b1, 1'b1);
        // bad tag without last, drained up to the last byte
        add_item(8'h00, 1'b0, 1'b1);     add_item(8'h66, 1'b1, 1'b1);
        wait_drained();

        // output held off while input keeps coming
        hold_request = 1'b1;
        run_random(60);
        wait_drained();

        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        run_random(60);
        wait_drained();

        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        run_random(70);
        wait_drained();

        repeat (80) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
design/lzd_pkg.sv
design/lzd_ctrl.sv
design/lzd_dp.sv
design/lz77_stream_decompressor_top.sv
bench/lz77_stream_decompressor_top_tb.sv
